// File: rtl/obdrd_pkg.sv
// Package: shared types, PID table and formula codes for the OBD response decoder.
`default_nettype none
package obdrd_pkg;

    localparam int TABLE_SIZE = 30;
    localparam logic [10:0] ID_LOW = 11'h7E8;
    localparam logic [10:0] ID_HIGH = 11'h7EF;
    localparam logic [7:0] MODE_RESPONSE = 8'h41;

    typedef enum logic [3:0] {
        F_NONE, F_PCT, F_M40, F_X3, F_A, F_Q4, F_ADV, F_D100, F_X,
        F_D1000, F_P255, F_D32K, F_FUEL, F_D20, F_M125
    } formula_t;

    typedef struct packed {
        logic load;
        logic write;
        logic sel_out;
    } dp_cmd_t;

    typedef struct packed {
        logic is_read;
        logic hit;
    } dp_stat_t;

    function automatic logic [7:0] pid_at(input logic [4:0] idx);
        logic [7:0] p;
        begin
            unique case (idx)
                5'd0: p = 8'h04; 5'd1: p = 8'h05; 5'd2: p = 8'h0A; 5'd3: p = 8'h0B;
                5'd4: p = 8'h0C; 5'd5: p = 8'h0D; 5'd6: p = 8'h0E; 5'd7: p = 8'h0F;
                5'd8: p = 8'h10; 5'd9: p = 8'h11; 5'd10: p = 8'h1F; 5'd11: p = 8'h21;
                5'd12: p = 8'h2F; 5'd13: p = 8'h31; 5'd14: p = 8'h33; 5'd15: p = 8'h42;
                5'd16: p = 8'h43; 5'd17: p = 8'h44; 5'd18: p = 8'h45; 5'd19: p = 8'h46;
                5'd20: p = 8'h47; 5'd21: p = 8'h49; 5'd22: p = 8'h4A; 5'd23: p = 8'h4C;
                5'd24: p = 8'h51; 5'd25: p = 8'h52; 5'd26: p = 8'h5C; 5'd27: p = 8'h5D;
                5'd28: p = 8'h5E; 5'd29: p = 8'h61;
                default: p = 8'h00;
            endcase
            return p;
        end
    endfunction

    function automatic formula_t formula_of(input logic [7:0] pid);
        formula_t f;
        begin
            unique case (pid)
                8'h04, 8'h11, 8'h2F, 8'h45, 8'h47, 8'h49, 8'h4A, 8'h4C, 8'h52: f = F_PCT;
                8'h05, 8'h0F, 8'h46, 8'h5C: f = F_M40;
                8'h0A: f = F_X3;
                8'h0B, 8'h0D, 8'h33, 8'h51: f = F_A;
                8'h0C: f = F_Q4;
                8'h0E: f = F_ADV;
                8'h10: f = F_D100;
                8'h1F, 8'h21, 8'h31: f = F_X;
                8'h42: f = F_D1000;
                8'h43: f = F_P255;
                8'h44: f = F_D32K;
                8'h5D: f = F_FUEL;
                8'h5E: f = F_D20;
                8'h61: f = F_M125;
                default: f = F_NONE;
            endcase
            return f;
        end
    endfunction

endpackage
`default_nettype wire

// File: rtl/obdrd_ctrl.sv
// Controller: sequences one request through decode, store update and result.
`default_nettype none
module obdrd_ctrl
    import obdrd_pkg::*;
(
    input  wire logic     aclk,
    input  wire logic     aresetn,
    input  wire logic     in_fire,
    input  wire logic     out_fire,
    input  wire dp_stat_t stat,
    output logic          in_ready,
    output logic          out_valid,
    output dp_cmd_t       cmd
);
    typedef enum logic [1:0] {S_IDLE, S_EXEC, S_HOLD} state_t;
    state_t state_reg;

    always_comb begin
        cmd.load = in_fire;
        cmd.write = (state_reg == S_EXEC) && !stat.is_read && stat.hit;
        cmd.sel_out = (state_reg == S_EXEC);
        in_ready = (state_reg == S_IDLE);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
            out_valid <= 1'b0;
        end else begin
            unique case (state_reg)
                S_IDLE: if (in_fire) state_reg <= S_EXEC;
                S_EXEC: begin
                    state_reg <= S_HOLD;
                    out_valid <= 1'b1;
                end
                S_HOLD: if (out_fire) begin
                    state_reg <= S_IDLE;
                    out_valid <= 1'b0;
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end
endmodule
`default_nettype wire

// File: rtl/obdrd_dp.sv
// Datapath: frame checks, PID lookup, value formulas, entry store and result register.
`default_nettype none
module obdrd_dp
    import obdrd_pkg::*;
#(
    parameter int ITEM_COUNT = 30
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire dp_cmd_t     cmd,
    input  wire logic        command,
    input  wire logic        extended_id,
    input  wire logic [10:0] frame_id,
    input  wire logic [3:0]  frame_length,
    input  wire logic [7:0]  mode_byte,
    input  wire logic [7:0]  pid_byte,
    input  wire logic [7:0]  byte_a,
    input  wire logic [7:0]  byte_b,
    input  wire logic [31:0] now_ms,
    input  wire logic [7:0]  read_index,
    output dp_stat_t         stat,
    output logic [79:0]      result
);
    // reciprocals for the small remainder divisions, exact over their ranges
    localparam logic [23:0] RCP_255  = 24'd8421505;   // ceil(2^31/255)
    localparam logic [22:0] RCP_100  = 23'd5368710;   // ceil(2^29/100)
    localparam logic [26:0] RCP_1000 = 27'd68719477;  // ceil(2^36/1000)
    localparam logic [20:0] RCP_20   = 21'd1677722;   // ceil(2^25/20)

    // latched request; frame checks are evaluated at accept and latched, lookup uses the latched copy
    logic        rd_reg, ok_reg;
    logic [7:0]  pid_reg, a_reg, b_reg, ridx_reg;
    logic [31:0] now_reg;

    logic [32:0] val_mem [TABLE_SIZE];
    logic [31:0] time_mem [TABLE_SIZE];
    logic [TABLE_SIZE-1:0] valid_reg;

    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            rd_reg <= command;
            ok_reg <= !extended_id && frame_id >= ID_LOW && frame_id <= ID_HIGH
                && frame_length >= 4'd4 && mode_byte == MODE_RESPONSE;
            pid_reg <= pid_byte;
            a_reg <= byte_a;
            b_reg <= byte_b;
            now_reg <= now_ms;
            ridx_reg <= read_index;
        end
    end

    // PID search over fixed table entries
    logic [4:0] hit_idx;
    logic hit_any;
    always_comb begin
        hit_idx = '0;
        hit_any = 1'b0;
        for (int i = 0; i < ITEM_COUNT; i++) begin
            if (!hit_any && pid_at(5'(i)) == pid_reg) begin
                hit_any = 1'b1;
                hit_idx = 5'(i);
            end
        end
    end

    // rounded N*2^16/d split as k*N + (r*N + d/2)/d with 2^16 = k*d + r;
    // the remainder quotient comes from a reciprocal multiply
    logic [15:0] x;
    logic [22:0] m255, n255;
    logic [46:0] q255;
    logic [21:0] n100;
    logic [44:0] q100;
    logic [25:0] n1000;
    logic [52:0] q1000;
    logic [19:0] n20;
    logic [40:0] q20;
    logic [32:0] dv;
    always_comb begin
        x = {a_reg, b_reg};
        m255 = (formula_of(pid_reg) == F_P255) ? 23'(x) * 23'd100 : 23'(a_reg) * 23'd100;
        n255 = m255 + 23'd127;
        q255 = 47'(n255) * 47'(RCP_255);
        n100 = 22'(x) * 22'd36 + 22'd50;
        q100 = 45'(n100) * 45'(RCP_100);
        n1000 = 26'(x) * 26'd536 + 26'd500;
        q1000 = 53'(n1000) * 53'(RCP_1000);
        n20 = {x, 4'd0} + 20'd10;
        q20 = 41'(n20) * 41'(RCP_20);
        unique case (formula_of(pid_reg))
            F_PCT, F_P255: dv = 33'(m255) * 33'd257 + 33'(q255[46:31]);
            F_M40:  dv = (33'(a_reg) - 33'd40) << 16;
            F_X3:   dv = 33'({25'(a_reg) * 25'd3, 16'd0});
            F_A:    dv = 33'({a_reg, 16'd0});
            F_Q4:   dv = 33'({x, 14'd0});
            F_ADV:  dv = 33'({a_reg, 15'd0}) - 33'h40_0000;
            F_D100: dv = 33'(x) * 33'd655 + 33'(q100[44:29]);
            F_X:    dv = {1'b0, x, 16'd0};
            F_D1000: dv = 33'(x) * 33'd65 + 33'(q1000[52:36]);
            F_D32K: dv = 33'({x, 1'b0});
            F_FUEL: dv = 33'({x, 9'd0}) - 33'(32'd210 << 16);
            F_D20:  dv = 33'(x) * 33'd3276 + 33'(q20[40:25]);
            F_M125: dv = (33'(a_reg) - 33'd125) << 16;
            default: dv = '0;
        endcase
    end

    logic [4:0] idx;
    logic show;
    always_comb begin
        stat.is_read = rd_reg;
        stat.hit = ok_reg && hit_any;
        idx = rd_reg ? ridx_reg[4:0] : hit_idx;
        show = rd_reg ? (ridx_reg < 8'(ITEM_COUNT)) : (ok_reg && hit_any);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= '0;
        end else if (cmd.write) begin
            valid_reg[hit_idx] <= 1'b1;
        end
    end
    always_ff @(posedge aclk) begin
        if (cmd.write) begin
            val_mem[hit_idx] <= dv;
            time_mem[hit_idx] <= now_reg;
        end
    end

    // result: {time, valid, value, pid, index, accepted}
    always_ff @(posedge aclk) begin
        if (cmd.sel_out) begin
            if (!show) result <= '0;
            else if (!rd_reg) result <= {now_reg, 1'b1, dv, pid_at(idx), idx, 1'b1};
            else result <= {valid_reg[idx] ? time_mem[idx] : 32'd0, valid_reg[idx],
                valid_reg[idx] ? val_mem[idx] : 33'd0, pid_at(idx), idx, 1'b0};
        end
    end
endmodule
`default_nettype wire

// File: rtl/obd_response_decoder_unit.sv
// Top level of the OBD-II mode 01 response decoder with entry store.
//  channel | dir | tdata fields (low bit up)                                | tuser
//  s_axis  | in  | ext,id,len,mode,pid,a,b,now,ridx (88b, no padding)        | command
//  m_axis  | out | accepted,index,pid,value,valid,time (80b, padded to 88)   | -
// A request is latched at accept, decoded and stored in the next cycle, and
// its result is valid from the cycle after that. A request passes through
// accept, execute and result handshake in turn; a new request is
// taken only after the result is delivered. Reset (aresetn low, synchronous)
// clears all entry valid bits at once; unwritten entries read zero value and time.
// m_tvalid holds through output stalls.
`default_nettype none
module obd_response_decoder_unit
    import obdrd_pkg::*;
#(
    parameter int ITEM_COUNT = 30
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [87:0] s_tdata,  // extended_id,frame_id,frame_length,mode_byte,
                                       // pid_byte,byte_a,byte_b,now_ms,read_index
    input  wire logic        s_tuser,  // command
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [87:0]      m_tdata   // frame_accepted,entry_index,entry_pid,
                                       // entry_value,entry_valid,entry_time
);
    dp_cmd_t  cmd;
    dp_stat_t stat;
    logic [79:0] result;

    obdrd_ctrl u_ctrl (
        .aclk(aclk), .aresetn(aresetn),
        .in_fire(s_tvalid && s_tready), .out_fire(m_tvalid && m_tready),
        .stat(stat), .in_ready(s_tready), .out_valid(m_tvalid), .cmd(cmd)
    );

    obdrd_dp #(.ITEM_COUNT(ITEM_COUNT)) u_dp (
        .aclk(aclk), .aresetn(aresetn), .cmd(cmd),
        .command(s_tuser), .extended_id(s_tdata[0]), .frame_id(s_tdata[11:1]),
        .frame_length(s_tdata[15:12]), .mode_byte(s_tdata[23:16]),
        .pid_byte(s_tdata[31:24]), .byte_a(s_tdata[39:32]), .byte_b(s_tdata[47:40]),
        .now_ms(s_tdata[79:48]), .read_index(s_tdata[87:80]),
        .stat(stat), .result(result)
    );

    // result packs to 80 bits; top byte zero
    assign m_tdata = {8'd0, result};
endmodule
`default_nettype wire

// File: rtl/obdrd_checker.sv
// Port-level checker for the decoder top level, with its bind.
`default_nettype none
module obdrd_checker (
    input wire logic        aclk,
    input wire logic        aresetn,
    input wire logic        s_tready,
    input wire logic        m_tvalid,
    input wire logic        m_tready,
    input wire logic [87:0] m_tdata
);
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata)) else $error("result dropped");
    a_excl: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> !s_tready) else $error("accept while result pending");
    a_empty: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tdata[0] && m_tdata[13:6] == 8'd0 |-> m_tdata[5:1] == 5'd0)
        else $error("empty entry with index");
    a_acc: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tdata[0] |-> m_tdata[47]) else $error("accepted but not valid");
endmodule

bind obd_response_decoder_unit obdrd_checker u_chk (
    .aclk(aclk), .aresetn(aresetn), .s_tready(s_tready),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
);
`default_nettype wire

// File: test/tb_obd_response_decoder_unit.sv
// Testbench for the OBD-II mode 01 response decoder: random and directed requests, scoreboard.
module tb_obd_response_decoder_unit;
    timeunit 1ns;
    timeprecision 1ps;
    import obdrd_pkg::*;

    localparam int NUM_ENTRIES = 30;
    localparam int CYCLE_LIMIT = 400000;
    localparam logic CMD_FRAME = 1'b0;
    localparam logic CMD_READ  = 1'b1;

    logic        aclk;
    logic        aresetn;
    logic        s_tvalid;
    logic        s_tready;
    logic [87:0] s_tdata;
    logic        s_tuser;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [87:0] m_tdata;

    // request fields
    typedef struct packed {
        logic        cmd;
        logic        ext;
        logic [10:0] id;
        logic [3:0]  len;
        logic [7:0]  mode;
        logic [7:0]  pid;
        logic [7:0]  a;
        logic [7:0]  b;
        logic [31:0] now;
        logic [7:0]  ridx;
    } obd_req_t;

    // result fields, high bits first
    typedef struct packed {
        logic [31:0] stamp;
        logic        valid;
        logic [32:0] value;
        logic [7:0]  pid;
        logic [4:0]  index;
        logic        accepted;
    } entry_rsp_t;

    obd_response_decoder_unit #(.ITEM_COUNT(NUM_ENTRIES)) u_top (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
    );

    // PID table, entry order
    logic [7:0] pid_list [NUM_ENTRIES] = '{
        8'h04, 8'h05, 8'h0A, 8'h0B, 8'h0C, 8'h0D, 8'h0E, 8'h0F, 8'h10, 8'h11,
        8'h1F, 8'h21, 8'h2F, 8'h31, 8'h33, 8'h42, 8'h43, 8'h44, 8'h45, 8'h46,
        8'h47, 8'h49, 8'h4A, 8'h4C, 8'h51, 8'h52, 8'h5C, 8'h5D, 8'h5E, 8'h61};

    // predictor's copy of the entry store
    logic [32:0] mdl_value [NUM_ENTRIES];
    logic        mdl_valid [NUM_ENTRIES];
    logic [31:0] mdl_stamp [NUM_ENTRIES];

    entry_rsp_t  pending_entries [$];
    int          mismatch_count = 0;
    int          cycle_count = 0;
    int          send_idle_pct;
    int          recv_stall_pct;

    always begin
        aclk = 1'b0; #10;
        aclk = 1'b1; #10;
    end

    // round(num * 2^16 / den), ties up
    function automatic logic [32:0] round_div(input longint unsigned num,
                                              input longint unsigned den);
        return 33'((num * 65536 + den / 2) / den);
    endfunction

    function automatic logic [32:0] scale_pid(input logic [7:0] pid, input logic [7:0] a,
                                              input logic [7:0] b);
        longint unsigned x;
        longint          s;
        x = longint'(a) * 256 + longint'(b);
        case (formula_of(pid))
            F_PCT:   return round_div(longint'(a) * 100, 255);
            F_M40:   s = (longint'(a) - 40) * 65536;
            F_X3:    s = longint'(a) * 3 * 65536;
            F_A:     s = longint'(a) * 65536;
            F_Q4:    return round_div(x, 4);
            F_ADV:   s = longint'(a) * 32768 - 64 * 65536;
            F_D100:  return round_div(x, 100);
            F_X:     s = longint'(x) * 65536;
            F_D1000: return round_div(x, 1000);
            F_P255:  return round_div(x * 100, 255);
            F_D32K:  return round_div(x, 32768);
            F_FUEL:  s = longint'(x) * 512 - 210 * 65536;
            F_D20:   return round_div(x, 20);
            F_M125:  s = (longint'(a) - 125) * 65536;
            default: s = 0;
        endcase
        return s[32:0];
    endfunction

    function automatic entry_rsp_t show_entry(input logic acc, input int idx);
        entry_rsp_t r;
        r.accepted = acc;
        r.index    = 5'(idx);
        r.pid      = pid_list[idx];
        r.value    = mdl_value[idx];
        r.valid    = mdl_valid[idx];
        r.stamp    = mdl_stamp[idx];
        return r;
    endfunction

    // updates the store and returns the expected result
    function automatic entry_rsp_t predict_entry(input obd_req_t q);
        int hit;
        hit = -1;
        if (q.cmd == CMD_READ)
            return (q.ridx < NUM_ENTRIES) ? show_entry(1'b0, q.ridx) : '0;
        if (q.ext || q.id < ID_LOW || q.id > ID_HIGH || q.len < 4 || q.mode != MODE_RESPONSE)
            return '0;
        for (int i = 0; i < NUM_ENTRIES; i++)
            if (hit < 0 && pid_list[i] == q.pid) hit = i;
        if (hit < 0) return '0;
        mdl_value[hit] = scale_pid(q.pid, q.a, q.b);
        mdl_valid[hit] = 1'b1;
        mdl_stamp[hit] = q.now;
        return show_entry(1'b1, hit);
    endfunction

    // s_tvalid stays up after an accept until the next request or an idle cycle
    task automatic send_request(input obd_req_t q);
        while ($urandom_range(99) < send_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= q.cmd;
        s_tdata  <= {q.ridx, q.now, q.b, q.a, q.pid, q.mode, q.len, q.id, q.ext};
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        pending_entries.push_back(predict_entry(q));
    endtask

    // well-formed response frame for a table PID
    function automatic obd_req_t good_frame(input int idx);
        obd_req_t q;
        q      = '0;
        q.cmd  = CMD_FRAME;
        q.id   = ID_LOW + 11'($urandom_range(7));
        q.len  = 4'($urandom_range(8, 4));
        q.mode = MODE_RESPONSE;
        q.pid  = pid_list[idx];
        q.a    = 8'($urandom);
        q.b    = 8'($urandom);
        q.now  = $urandom;
        q.ridx = 8'($urandom);
        return q;
    endfunction

    function automatic obd_req_t read_req(input logic [7:0] idx);
        obd_req_t q;
        q      = '0;
        q.cmd  = CMD_READ;
        q.ridx = idx;
        return q;
    endfunction

    task automatic test_directed();
        obd_req_t q;
        send_request(read_req(8'd0));          // read before any write
        send_request(read_req(8'd29));
        send_request(read_req(8'd30));         // out of range
        send_request(read_req(8'hFF));
        // extremes of A and B across all table PIDs
        for (int i = 0; i < 3; i++) begin
            foreach (pid_list[k]) begin
                q = good_frame(k);
                q.a = (i == 0) ? 8'h00 : 8'hFF;
                q.b = (i == 1) ? 8'h00 : 8'hFF;
                q.now = (i == 2) ? 32'hFFFF_FFFF : 32'd0;
                if (i == 2) q.len = 4'd4;   // minimum accepted length
                if (k % 3 == i) send_request(q);
            end
        end
        q = good_frame(0); q.ext = 1'b1; send_request(q);
        q = good_frame(1); q.id = ID_LOW - 1; send_request(q);
        q = good_frame(1); q.id = ID_HIGH + 1; send_request(q);
        q = good_frame(2); q.len = 4'd3; send_request(q);
        q = good_frame(2); q.mode = 8'h42; send_request(q);
        q = good_frame(3); q.pid = 8'h00; send_request(q);
        q = good_frame(3); q.id = ID_HIGH; q.len = 4'd15; send_request(q);
        send_request(read_req(8'd4));
    endtask

    task automatic test_random(input int count);
        obd_req_t q;
        int pick;
        for (int n = 0; n < count; n++) begin
            pick = $urandom_range(99);
            if (pick < 45) begin
                q = good_frame($urandom_range(NUM_ENTRIES - 1));
            end else if (pick < 70) begin
                q = read_req(($urandom_range(9) == 0) ? 8'($urandom)
                                                       : 8'($urandom_range(NUM_ENTRIES - 1)));
                q.ext = 1'($urandom); q.id = 11'($urandom); q.now = $urandom;
            end else if (pick < 88) begin
                // near-miss frame: randomise one checked field
                q = good_frame($urandom_range(NUM_ENTRIES - 1));
                case ($urandom_range(4))
                    0: q.ext = 1'b1;
                    1: q.id = 11'($urandom);
                    2: q.len = 4'($urandom_range(15));
                    3: q.mode = 8'($urandom);
                    default: q.pid = 8'($urandom);
                endcase
            end else begin
                q = obd_req_t'(89'({$urandom, $urandom, $urandom}));
            end
            send_request(q);
        end
    endtask

    task automatic run_phase(input int idle_pct, input int stall_pct, input int count);
        send_idle_pct  = idle_pct;
        recv_stall_pct = stall_pct;
        test_random(count);
    endtask

    // response checker
    always @(posedge aclk) begin
        entry_rsp_t got;
        entry_rsp_t want;
        if (aresetn && m_tvalid && m_tready) begin
            got = entry_rsp_t'(m_tdata[79:0]);
            if (pending_entries.size() == 0) begin
                mismatch_count++;
                if (mismatch_count <= 10) $display("unexpected response %h", got);
            end else begin
                want = pending_entries.pop_front();
                if (got !== want || m_tdata[87:80] !== 8'd0) begin
                    mismatch_count++;
                    if (mismatch_count <= 10)
                        $display({"mismatch: exp acc=%0d idx=%0d pid=%h val=%h v=%0d t=%h,",
                                  " got acc=%0d idx=%0d pid=%h val=%h v=%0d t=%h"},
                                 want.accepted, want.index, want.pid, want.value, want.valid,
                                 want.stamp, got.accepted, got.index, got.pid, got.value,
                                 got.valid, got.stamp);
                end
            end
        end
        m_tready <= ($urandom_range(99) >= recv_stall_pct);
    end

    // watchdog
    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("Verification failed");
            $finish;
        end
    end

    initial begin
        aresetn        = 1'b0;
        s_tvalid       = 1'b0;
        s_tdata        = '0;
        s_tuser        = 1'b0;
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        for (int i = 0; i < NUM_ENTRIES; i++) begin
            mdl_value[i] = '0;
            mdl_valid[i] = 1'b0;
            mdl_stamp[i] = '0;
        end
        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        test_directed();
        run_phase(0, 0, 360);
        run_phase(45, 0, 360);
        run_phase(0, 45, 360);
        run_phase(22, 22, 360);
        s_tvalid <= 1'b0;

        while (pending_entries.size() != 0) @(posedge aclk);
        repeat (10) @(posedge aclk);
        if (mismatch_count == 0 && pending_entries.size() == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end
endmodule
